// ----- design/lksc_pkg.sv -----
// shared types, constants and the seven-segment table of the led/key serial controller
// no dependencies; used by lksc_front, lksc_back and led_key_serial_controller
package lksc_pkg;

   // sequence sizes
   localparam int Digits     = 8;
   localparam int ClearBytes = 16;
   localparam int KeyBytes   = 4;

   // last frame step of each sequence
   localparam logic [5:0] CLEAR_LAST   = 6'(4 + ClearBytes);
   localparam logic [5:0] REFRESH_LAST = 6'(2 + 7 * Digits);
   localparam logic [5:0] SCAN_LAST    = 6'(2 + KeyBytes);

   // request op codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_SCAN    = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   // chip command bytes
   localparam logic [7:0] CMD_CLEAR     = 8'h40;
   localparam logic [7:0] CMD_FIXED     = 8'h44;
   localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
   localparam logic [7:0] CMD_READ      = 8'h42;
   localparam logic [7:0] DISP_RESET    = 8'h8F;

   typedef enum logic [1:0] {
      KIND_IDLE,
      KIND_CLEAR,
      KIND_REFRESH,
      KIND_SCAN
   } kind_type;

   // classified request, passed from front to back
   typedef struct packed {
      logic       wr_digit;
      kind_type   start;
      logic [2:0] pos;
      logic [3:0] value;
      logic       din;
   } cmd_type;

   // pin levels and status of one tick, strobe in the lowest bit
   typedef struct packed {
      logic       busy;
      logic [7:0] keys;
      logic       drive;
      logic       dat;
      logic       clk;
      logic       strobe;
   } pins_type;

   // seven-segment code, codes above nine blank
   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h3F;
         4'd1: s = 8'h06;
         4'd2: s = 8'h5B;
         4'd3: s = 8'h4F;
         4'd4: s = 8'h66;
         4'd5: s = 8'h6D;
         4'd6: s = 8'h7D;
         4'd7: s = 8'h07;
         4'd8: s = 8'h7F;
         4'd9: s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

// ----- design/lksc_front.sv -----
// front end: accepts requests, decodes the op and queues them in a two-entry fifo
// depends on lksc_pkg
module lksc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [2:0]       req_tuser,
   output logic             head_valid,
   output lksc_pkg::cmd_type head,
   input  logic             head_pop
);
   import lksc_pkg::*;

   cmd_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push;

   // classify the incoming request
   always_comb begin
      cmd.wr_digit = (req_tuser == OP_WRITE);
      case (req_tuser)
         OP_REFRESH: cmd.start = KIND_REFRESH;
         OP_SCAN:    cmd.start = KIND_SCAN;
         OP_CLEAR:   cmd.start = KIND_CLEAR;
         default:    cmd.start = KIND_IDLE;
      endcase
      cmd.pos   = req_tdata[2:0];
      cmd.value = req_tdata[6:3];
      cmd.din   = req_tdata[7];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = fifo_ff[rd_ptr_ff];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, head_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ----- design/lksc_back.sv -----
// back end: digit store, frame sequencer and the registered response stage
// depends on lksc_pkg
module lksc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [7:0]       csr_wdata,
   input  logic             head_valid,
   input  lksc_pkg::cmd_type head,
   output logic             head_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata
);
   import lksc_pkg::*;

   typedef enum logic [1:0] {
      SLOT_START,
      SLOT_OUT,
      SLOT_READ,
      SLOT_END
   } slot_type;

   logic [7:0]                disp_ctrl_ff;
   logic [7:0][3:0]           digits_ff, digits_in;
   kind_type                  kind_ff, kind_in, kind_cur;
   logic [5:0]                step_ff, step_in, step_cur;
   logic [3:0]                phase_ff, phase_in, phase_cur;
   logic [2:0]                dig_ff, dig_in, dig_cur;
   logic [2:0]                sub_ff, sub_in, sub_cur;
   logic [7:0]                shift_ff, shift_in, shift_cur;
   logic [3:0][7:0]           kbytes_ff, kbytes_in, kbytes_cur;
   logic [7:0]                keys_ff, keys_in;
   logic                      out_valid_ff;
   pins_type                  out_pins_ff, pins;
   logic                      start_now, last, step_inc;
   slot_type                  slot;
   logic [7:0]                val;
   logic [1:0]                kidx;

   assign head_pop   = head_valid && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_pins_ff};

   // apply digit write and start ahead of the tick
   always_comb begin
      digits_in = digits_ff;
      if (head.wr_digit) begin
         digits_in[head.pos] = head.value;
      end
      start_now  = (kind_ff == KIND_IDLE) && (head.start != KIND_IDLE);
      kind_cur   = start_now ? head.start : kind_ff;
      step_cur   = start_now ? 6'd0 : step_ff;
      phase_cur  = start_now ? 4'd0 : phase_ff;
      dig_cur    = start_now ? 3'd0 : dig_ff;
      sub_cur    = start_now ? 3'd0 : sub_ff;
      kbytes_cur = (start_now && head.start == KIND_SCAN) ? '0 : kbytes_ff;
   end

   // slot decode for the current frame step
   always_comb begin
      slot = SLOT_END;
      val  = 8'h00;
      last = 1'b0;
      case (kind_cur)
         KIND_CLEAR: begin
            if (step_cur == 6'd0 || step_cur == 6'd3) slot = SLOT_START;
            else if (step_cur == 6'd1) begin
               slot = SLOT_OUT;
               val  = CMD_CLEAR;
            end else if (step_cur == 6'd2) slot = SLOT_END;
            else if (step_cur < CLEAR_LAST) slot = SLOT_OUT;
            else last = 1'b1;
         end
         KIND_REFRESH: begin
            if (step_cur == 6'd0) slot = SLOT_START;
            else if (step_cur == 6'd1) begin
               slot = SLOT_OUT;
               val  = disp_ctrl_ff;
            end else if (step_cur == 6'd2) slot = SLOT_END;
            else if (step_cur >= REFRESH_LAST) last = 1'b1;
            else begin
               case (sub_cur)
                  3'd0, 3'd3: slot = SLOT_START;
                  3'd1: begin
                     slot = SLOT_OUT;
                     val  = CMD_FIXED;
                  end
                  3'd4: begin
                     slot = SLOT_OUT;
                     val  = CMD_ADDR_BASE + {4'b0000, dig_cur, 1'b0};
                  end
                  3'd5: begin
                     slot = SLOT_OUT;
                     val  = seg_code(digits_in[dig_cur]);
                  end
                  default: slot = SLOT_END;
               endcase
            end
         end
         KIND_SCAN: begin
            if (step_cur == 6'd0) slot = SLOT_START;
            else if (step_cur == 6'd1) begin
               slot = SLOT_OUT;
               val  = CMD_READ;
            end else if (step_cur < SCAN_LAST) slot = SLOT_READ;
            else last = 1'b1;
         end
         default: slot = SLOT_END;
      endcase
   end

   // one pin phase of the running sequence
   always_comb begin
      kind_in   = kind_cur;
      step_in   = step_cur;
      phase_in  = phase_cur;
      dig_in    = dig_cur;
      sub_in    = sub_cur;
      shift_in  = shift_ff;
      kbytes_in = kbytes_cur;
      keys_in   = keys_ff;
      step_inc  = 1'b0;
      shift_cur = shift_ff;
      kidx      = 2'(step_cur - 6'd2);
      pins      = '{busy: 1'b0, keys: 8'h00, drive: 1'b1, dat: 1'b1, clk: 1'b1, strobe: 1'b1};
      if (kind_cur != KIND_IDLE) begin
         pins.busy = 1'b1;
         case (slot)
            SLOT_START: begin
               pins.strobe = 1'b0;
               step_inc    = 1'b1;
            end
            SLOT_OUT: begin
               shift_cur   = (phase_cur == 4'd0) ? val : shift_ff;
               shift_in    = shift_cur;
               pins.strobe = 1'b0;
               pins.clk    = phase_cur[0];
               pins.dat    = shift_cur[phase_cur[3:1]];
            end
            SLOT_READ: begin
               pins.strobe = 1'b0;
               pins.drive  = 1'b0;
               if (!phase_cur[0]) begin
                  shift_cur = (phase_cur == 4'd0) ? 8'h00 : shift_ff;
                  shift_in  = shift_cur | (8'(head.din) << phase_cur[3:1]);
               end else begin
                  pins.clk = 1'b0;
                  if (phase_cur == 4'd15) begin
                     kbytes_in[kidx] = shift_ff;
                  end
               end
            end
            default: begin
               if (kind_cur == KIND_SCAN) begin
                  keys_in = 8'h00;
                  for (int n = 0; n < KeyBytes; n++) begin
                     keys_in[n]     = kbytes_cur[n][1];
                     keys_in[n + 4] = kbytes_cur[n][5];
                  end
               end
               if (last) begin
                  kind_in = KIND_IDLE;
                  step_in = 6'd0;
               end else begin
                  step_inc = 1'b1;
               end
               phase_in = 4'd0;
            end
         endcase
         if (slot == SLOT_OUT || slot == SLOT_READ) begin
            if (phase_cur == 4'd15) begin
               phase_in = 4'd0;
               step_inc = 1'b1;
            end else begin
               phase_in = 4'(phase_cur + 4'd1);
            end
         end
      end
      // step counter, digit and sub-step tracking within the refresh
      if (step_inc) begin
         step_in = 6'(step_cur + 6'd1);
         if (kind_cur == KIND_REFRESH && step_cur >= 6'd3) begin
            if (sub_cur == 3'd6) begin
               sub_in = 3'd0;
               dig_in = 3'(dig_cur + 3'd1);
            end else begin
               sub_in = 3'(sub_cur + 3'd1);
            end
         end
      end
      pins.keys = keys_in;
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ctrl_ff <= DISP_RESET;
         digits_ff    <= {8{4'd8}};
         kind_ff      <= KIND_IDLE;
         step_ff      <= 6'd0;
         phase_ff     <= 4'd0;
         dig_ff       <= 3'd0;
         sub_ff       <= 3'd0;
         shift_ff     <= 8'h00;
         kbytes_ff    <= '0;
         keys_ff      <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            disp_ctrl_ff <= csr_wdata;
         end
         if (head_pop) begin
            digits_ff   <= digits_in;
            kind_ff     <= kind_in;
            step_ff     <= step_in;
            phase_ff    <= phase_in;
            dig_ff      <= dig_in;
            sub_ff      <= sub_in;
            shift_ff    <= shift_in;
            kbytes_ff   <= kbytes_in;
            keys_ff     <= keys_in;
            out_pins_ff <= pins;
         end
         if (head_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- design/led_key_serial_controller.sv -----
// top level of the led/key serial controller: front queue and back sequencer
// depends on lksc_pkg, lksc_front and lksc_back
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/req_tready tdata {data_in, digit_value, digit_position}, tuser op
//   rsp      out        rsp_tvalid/rsp_tready tdata {busy, keys, drive, data, clock, strobe}
//   csr      in         csr_wen               csr_wdata display control byte
//
// one request gives one response; a request is accepted every cycle while the queue has room.
// it is registered in the decode queue, then its sequencer step goes into the response register.
// each request advances the serial sequence by exactly one pin phase.
// synchronous active-high reset: lines idle high, digits all eight, control byte 0x8F.
// a stalled response holds the sequencer; the two-entry queue then fills and drops req_tready.
module led_key_serial_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] digit_position, [6:3] digit_value, [7] data_in
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] strobe_res, [1] clock_res, [2] data_out,
                                    // [3] data_drive, [11:4] keys, [12] busy_res, rest zero
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);
   import lksc_pkg::*;

   logic    head_valid;
   logic    head_pop;
   cmd_type head;

   // request decode and queue
   lksc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   // sequencer and response stage
   lksc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
